// ===== src/cbm_pkg.sv =====
package cbm_pkg;

    // size defaults for the stores
    localparam int CBM_MAX_ROWS   = 128;
    localparam int CBM_MAX_COLS   = 128;
    localparam int CBM_MAX_KERNEL = 7;

    // fixed field widths
    localparam int REQ_W      = 2;
    localparam int COORD_W    = 7;
    localparam int VALUE_W    = 16;
    localparam int PROD_W     = 2 * VALUE_W;
    localparam int RESULT_W   = 40;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int IMG_DIM_W  = 8;
    localparam int KER_DIM_W  = 3;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_COEF    = 2'd0,
        REQ_PIXEL   = 2'd1,
        REQ_COMPUTE = 2'd2
    } t_req;

    // border handling
    typedef enum logic [1:0] {
        BORDER_ZERO     = 2'd0,
        BORDER_CLAMP    = 2'd1,
        BORDER_MIRROR   = 2'd2,
        BORDER_PERIODIC = 2'd3
    } t_border;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK          = 2'd0,
        STATUS_EVEN_KERNEL = 2'd1,
        STATUS_OUTSIDE     = 2'd2
    } t_status;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_ROWS  = 3'd0,
        CFG_IMAGE_COLS  = 3'd1,
        CFG_KERNEL_ROWS = 3'd2,
        CFG_KERNEL_COLS = 3'd3,
        CFG_BORDER_MODE = 3'd4
    } t_cfg_idx;

endpackage

// ===== src/cbm_ram.sv =====
module cbm_ram
    import cbm_pkg::*;
#(
    parameter int WIDTH = VALUE_W,
    parameter int DEPTH = CBM_MAX_KERNEL * CBM_MAX_KERNEL,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/cbm_fold.sv =====
module cbm_fold
    import cbm_pkg::*;
#(
    parameter int FW    = 13,
    parameter int STEPS = 3
) (
    input  logic signed [FW-1:0] i_raw,
    input  logic signed [FW-1:0] i_n,
    input  t_border              i_mode,
    output logic signed [FW-1:0] o_idx,
    output logic                 o_skip
);

    logic signed [FW-1:0] m;
    logic signed [FW-1:0] period;

    // map a neighbor coordinate into the image, overshoot is at most STEPS
    always_comb begin
        m      = i_raw;
        period = i_n;
        o_idx  = i_raw;
        o_skip = 1'b0;
        if (i_raw < 0 || i_raw >= i_n) begin
            unique case (i_mode)
                BORDER_ZERO: begin
                    o_skip = 1'b1;
                    o_idx  = '0;
                end
                BORDER_CLAMP: begin
                    o_idx = (i_raw < 0) ? '0 : i_n - FW'(1);
                end
                BORDER_MIRROR, BORDER_PERIODIC: begin
                    period = (i_mode == BORDER_MIRROR) ? (i_n <<< 1) : i_n;
                    for (int k = 0; k < STEPS; k++) begin
                        if (m < 0) begin
                            m = m + period;
                        end else if (m >= period) begin
                            m = m - period;
                        end
                    end
                    if (i_mode == BORDER_MIRROR && m >= i_n) begin
                        o_idx = period - FW'(1) - m;
                    end else begin
                        o_idx = m;
                    end
                end
                default: begin
                    o_skip = 1'b1;
                    o_idx  = '0;
                end
            endcase
        end
    end

endmodule

// ===== src/correlation_2d_border_modes_unit.sv =====
// channel   | valid       | stall        | payload
// ----------+-------------+--------------+-----------------------------------------
// cfg write | i_cfg_we    | (none)       | i_cfg_index, i_cfg_data
// input     | i_in_valid  | o_in_stall   | i_req_type, i_row, i_col, i_value
// output    | o_out_valid | i_out_stall  | o_result, o_status
//
// a write beat is done once accepted; a compute beat runs through the accepting cycle,
// one tap a cycle through the single image memory read port, a drain (fold, read,
// multiply, accumulate) and the output load. flagged computes skip the taps and go
// straight to the output load. synchronous active low reset clears control only;
// both stores hold garbage until written. a result waiting under i_out_stall holds the
// next finished compute in its load cycle, with the input stalled, until it is taken
module correlation_2d_border_modes_unit
    import cbm_pkg::*;
#(
    parameter int MAX_ROWS   = CBM_MAX_ROWS,
    parameter int MAX_COLS   = CBM_MAX_COLS,
    parameter int MAX_KERNEL = CBM_MAX_KERNEL
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [COORD_W-1:0]    i_row,
    input  logic [COORD_W-1:0]    i_col,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [RESULT_W-1:0] o_result,
    output logic [STATUS_W-1:0]   o_status
);

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int IDEPTH = MAX_ROWS * MAX_COLS;
    localparam int KDEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int IAW = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;
    localparam int KAW = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
    localparam int KW  = $clog2(MAX_KERNEL + 1);
    localparam int FW  = $clog2(MAX_ROWS + MAX_COLS + MAX_KERNEL + 256) + 3;
    localparam int STEPS = (MAX_KERNEL / 2 > 0) ? MAX_KERNEL / 2 : 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [IMG_DIM_W-1:0] r_cfg_rows, r_cfg_cols;
    logic [KER_DIM_W-1:0] r_cfg_krows, r_cfg_kcols;
    t_border              r_cfg_mode;

    // per compute context
    logic signed [FW-1:0] r_row_f, r_col_f, r_nr, r_nc, r_hr, r_hc;
    logic [KW-1:0]        r_kr_last, r_kc_last, r_ta, r_tb;
    t_border              r_mode;
    t_status              r_status;
    logic signed [RESULT_W-1:0] r_acc;

    // tap pipeline
    logic                 r_p1_valid, r_p1_skip;
    logic [ROW_W-1:0]     r_p1_y;
    logic [COL_W-1:0]     r_p1_x;
    logic [KAW-1:0]       r_p1_kaddr;
    logic                 r_p2_valid, r_p2_skip;
    logic                 r_p3_valid;
    logic signed [PROD_W-1:0] r_prod;

    // output register
    logic                 r_out_valid;
    logic signed [RESULT_W-1:0] r_out_result;
    t_status              r_out_status;

    logic in_beat, is_coef, is_pixel, is_compute, tap_last, pipe_empty, emit_load;
    logic signed [FW-1:0] kr_f, kc_f, nr_f, nc_f, row_f, col_f;
    logic signed [FW-1:0] raw_y, raw_x, fy, fx;
    logic fy_skip, fx_skip, kernel_even, pos_out;
    logic coef_we, pix_we;
    logic [KAW-1:0] kwaddr;
    logic [IAW-1:0] iwaddr, iraddr;
    logic signed [VALUE_W-1:0] kdata, idata;
    logic signed [PROD_W-1:0] tap_prod;

    assign in_beat    = i_in_valid && !o_in_stall;
    assign is_coef    = (i_req_type == REQ_COEF);
    assign is_pixel   = (i_req_type == REQ_PIXEL);
    assign is_compute = (i_req_type == REQ_COMPUTE);

    // clamped sizes and compute checks from the live registers
    assign row_f = FW'(i_row);
    assign col_f = FW'(i_col);
    assign kr_f  = (FW'(r_cfg_krows) > FW'(MAX_KERNEL)) ? FW'(MAX_KERNEL) : FW'(r_cfg_krows);
    assign kc_f  = (FW'(r_cfg_kcols) > FW'(MAX_KERNEL)) ? FW'(MAX_KERNEL) : FW'(r_cfg_kcols);
    assign nr_f  = (r_cfg_rows == '0) ? FW'(1) :
                   ((FW'(r_cfg_rows) > FW'(MAX_ROWS)) ? FW'(MAX_ROWS) : FW'(r_cfg_rows));
    assign nc_f  = (r_cfg_cols == '0) ? FW'(1) :
                   ((FW'(r_cfg_cols) > FW'(MAX_COLS)) ? FW'(MAX_COLS) : FW'(r_cfg_cols));
    assign kernel_even = !kr_f[0] || !kc_f[0];
    assign pos_out     = (row_f >= nr_f) || (col_f >= nc_f);

    // store writes
    assign coef_we = in_beat && is_coef &&
                     (row_f < FW'(MAX_KERNEL)) && (col_f < FW'(MAX_KERNEL));
    assign pix_we  = in_beat && is_pixel &&
                     (row_f < FW'(MAX_ROWS)) && (col_f < FW'(MAX_COLS));
    assign kwaddr  = KAW'(32'(i_row) * MAX_KERNEL + 32'(i_col));
    assign iwaddr  = IAW'(32'(i_row) * MAX_COLS + 32'(i_col));
    assign iraddr  = IAW'(32'(r_p1_y) * MAX_COLS + 32'(r_p1_x));

    cbm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (KDEPTH)
    ) u_kernel_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (kwaddr),
        .i_wdata (i_value),
        .i_raddr (r_p1_kaddr),
        .o_rdata (kdata)
    );

    cbm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (IDEPTH)
    ) u_image_ram (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (iwaddr),
        .i_wdata (i_value),
        .i_raddr (iraddr),
        .o_rdata (idata)
    );

    // neighbor coordinates of the current tap
    assign raw_y = r_row_f + FW'(r_ta) - r_hr;
    assign raw_x = r_col_f + FW'(r_tb) - r_hc;

    cbm_fold #(.FW(FW), .STEPS(STEPS)) u_fold_row (
        .i_raw  (raw_y),
        .i_n    (r_nr),
        .i_mode (r_mode),
        .o_idx  (fy),
        .o_skip (fy_skip)
    );

    cbm_fold #(.FW(FW), .STEPS(STEPS)) u_fold_col (
        .i_raw  (raw_x),
        .i_n    (r_nc),
        .i_mode (r_mode),
        .o_idx  (fx),
        .o_skip (fx_skip)
    );

    assign tap_last   = (r_ta == r_kr_last) && (r_tb == r_kc_last);
    assign pipe_empty = !r_p1_valid && !r_p2_valid && !r_p3_valid;
    assign emit_load  = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);

    // signed tap product
    assign tap_prod = kdata * idata;

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat && is_compute) begin
                    n_state = (kernel_even || pos_out) ? ST_EMIT : ST_RUN;
                end
            end
            ST_RUN: begin
                if (tap_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (pipe_empty) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg_rows  <= IMG_DIM_W'(1);
            r_cfg_cols  <= IMG_DIM_W'(1);
            r_cfg_krows <= KER_DIM_W'(1);
            r_cfg_kcols <= KER_DIM_W'(1);
            r_cfg_mode  <= BORDER_ZERO;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_p3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_p1_valid <= (r_state == ST_RUN);
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_IMAGE_ROWS:  r_cfg_rows  <= i_cfg_data;
                    CFG_IMAGE_COLS:  r_cfg_cols  <= i_cfg_data;
                    CFG_KERNEL_ROWS: r_cfg_krows <= i_cfg_data[KER_DIM_W-1:0];
                    CFG_KERNEL_COLS: r_cfg_kcols <= i_cfg_data[KER_DIM_W-1:0];
                    CFG_BORDER_MODE: r_cfg_mode  <= t_border'(i_cfg_data[1:0]);
                    default: ;
                endcase
            end
        end
    end

    // compute context, tap counters and accumulator
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_beat && is_compute) begin
            r_row_f   <= row_f;
            r_col_f   <= col_f;
            r_nr      <= nr_f;
            r_nc      <= nc_f;
            r_hr      <= kr_f >>> 1;
            r_hc      <= kc_f >>> 1;
            r_kr_last <= KW'(kr_f - FW'(1));
            r_kc_last <= KW'(kc_f - FW'(1));
            r_mode    <= r_cfg_mode;
            r_ta      <= '0;
            r_tb      <= '0;
            r_acc     <= '0;
            r_status  <= kernel_even ? STATUS_EVEN_KERNEL :
                         (pos_out ? STATUS_OUTSIDE : STATUS_OK);
        end else begin
            if (r_state == ST_RUN) begin
                if (r_tb == r_kc_last) begin
                    r_tb <= '0;
                    r_ta <= r_ta + KW'(1);
                end else begin
                    r_tb <= r_tb + KW'(1);
                end
            end
            if (r_p3_valid) begin
                r_acc <= r_acc + RESULT_W'(r_prod);
            end
        end
    end

    // tap pipeline payload
    always_ff @(posedge i_clk) begin
        r_p1_skip  <= fy_skip || fx_skip;
        r_p1_y     <= ROW_W'(fy);
        r_p1_x     <= COL_W'(fx);
        r_p1_kaddr <= KAW'(32'(r_ta) * MAX_KERNEL + 32'(r_tb));
        r_p2_skip  <= r_p1_skip;
        r_prod     <= r_p2_skip ? '0 : tap_prod;
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_out_result <= r_acc;
            r_out_status <= r_status;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out_result;
    assign o_status    = r_out_status;

endmodule

// ===== verif/correlation_2d_border_modes_unit_test.sv =====
`timescale 1ns / 1ps

module correlation_2d_border_modes_unit_test;
    import cbm_pkg::*;

    localparam int IDLE_PCT      = 38;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 400;
    localparam int KER_TAPS      = CBM_MAX_KERNEL * CBM_MAX_KERNEL;
    localparam int IMG_PIXELS    = CBM_MAX_ROWS * CBM_MAX_COLS;

    // request code the block ignores, and a register index it does not decode
    localparam logic [REQ_W-1:0]     REQ_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct {
        logic [REQ_W-1:0]          req;
        logic [COORD_W-1:0]        row;
        logic [COORD_W-1:0]        col;
        logic signed [VALUE_W-1:0] value;
    } t_beat;

    typedef struct {
        logic signed [RESULT_W-1:0] result;
        t_status                    status;
    } t_sample;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data  = '0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_stall;
    logic [REQ_W-1:0]              i_req_type  = '0;
    logic [COORD_W-1:0]            i_row       = '0;
    logic [COORD_W-1:0]            i_col       = '0;
    logic signed [VALUE_W-1:0]     i_value     = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic signed [RESULT_W-1:0]    o_result;
    logic [STATUS_W-1:0]           o_status;

    // shadow of the block: registers and both stores
    logic [IMG_DIM_W-1:0]      rows_reg   = 8'd1;
    logic [IMG_DIM_W-1:0]      cols_reg   = 8'd1;
    logic [KER_DIM_W-1:0]      kr_reg     = 3'd1;
    logic [KER_DIM_W-1:0]      kc_reg     = 3'd1;
    t_border                   border_reg = BORDER_ZERO;
    logic signed [VALUE_W-1:0] img_mem  [IMG_PIXELS];
    logic signed [VALUE_W-1:0] coef_mem [KER_TAPS];

    // entries already covered by a queued write, so no compute reads garbage
    bit pix_set  [IMG_PIXELS];
    bit coef_set [KER_TAPS];

    t_beat   request_queue[$];
    t_sample expected_samples[$];
    int      issued_beats = 0;
    int      error_count  = 0;

    // flow control knobs set between phases
    bit steady_flow = 1'b0;
    bit hold_armed  = 1'b0;
    bit hold_used   = 1'b0;
    int hold_left   = 0;

    correlation_2d_border_modes_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (o_result),
        .o_status    (o_status)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // size registers: zero acts as one, anything above the store acts as the store
    function automatic int eff_dim(logic [IMG_DIM_W-1:0] v, int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // map a neighbor index into the image, -1 when the tap is dropped
    function automatic int fold_coord(int i, int n);
        int m;
        if (i >= 0 && i < n) return i;
        case (border_reg)
            BORDER_ZERO:  return -1;
            BORDER_CLAMP: return (i < 0) ? 0 : n - 1;
            BORDER_MIRROR: begin
                m = ((i % (2 * n)) + 2 * n) % (2 * n);
                return (m >= n) ? 2 * n - 1 - m : m;
            end
            default:      return ((i % n) + n) % n;
        endcase
    endfunction

    // expected output sample at one position
    function automatic t_sample correlate_at(int row, int col);
        t_sample s;
        int      nr, nc, kr, kc, y, x;
        longint  acc;
        nr = eff_dim(rows_reg, CBM_MAX_ROWS);
        nc = eff_dim(cols_reg, CBM_MAX_COLS);
        kr = kr_reg;
        kc = kc_reg;
        acc = 0;
        s.result = '0;
        s.status = STATUS_OK;
        if (!kr_reg[0] || !kc_reg[0]) begin
            s.status = STATUS_EVEN_KERNEL;
        end else if (row >= nr || col >= nc) begin
            s.status = STATUS_OUTSIDE;
        end else begin
            for (int a = 0; a < kr; a++) begin
                y = fold_coord(row + a - kr / 2, nr);
                if (y < 0) continue;
                for (int b = 0; b < kc; b++) begin
                    x = fold_coord(col + b - kc / 2, nc);
                    if (x < 0) continue;
                    acc += longint'(coef_mem[a * CBM_MAX_KERNEL + b]) *
                           longint'(img_mem[y * CBM_MAX_COLS + x]);
                end
            end
            s.result = acc[RESULT_W-1:0];
        end
        return s;
    endfunction

    // update the shadow stores or queue the expected sample for one accepted beat
    task automatic apply_beat(logic [REQ_W-1:0] req, int row, int col,
                              logic signed [VALUE_W-1:0] value);
        case (req)
            REQ_COEF: begin
                if (row < CBM_MAX_KERNEL && col < CBM_MAX_KERNEL)
                    coef_mem[row * CBM_MAX_KERNEL + col] = value;
            end
            REQ_PIXEL: begin
                if (row < CBM_MAX_ROWS && col < CBM_MAX_COLS)
                    img_mem[row * CBM_MAX_COLS + col] = value;
            end
            REQ_COMPUTE: expected_samples.push_back(correlate_at(row, col));
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t ns: %s mismatch, got %0d, want %0d", $time, what, got, want);
        error_count++;
    endtask

    // output check first, then the input beat of the same edge
    always @(posedge i_clk) begin : scoreboard
        t_sample want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch("unexpected sample", longint'(o_result), 0);
                end else begin
                    want = expected_samples.pop_front();
                    if (o_result !== want.result)
                        report_mismatch("result", longint'(o_result), longint'(want.result));
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                end
            end
            if (i_in_valid && !o_in_stall)
                apply_beat(i_req_type, i_row, i_col, i_value);
        end
    end

    // input beat driver, random gaps unless steady flow is on
    always @(posedge i_clk) begin : request_driver
        t_beat nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (request_queue.size() != 0 &&
                (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
                nxt = request_queue.pop_front();
                i_in_valid <= 1'b1;
                i_req_type <= nxt.req;
                i_row      <= nxt.row;
                i_col      <= nxt.col;
                i_value    <= nxt.value;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output stall: random, one long hold when armed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_armed && !hold_used) begin
            hold_used   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !steady_flow && ($urandom_range(99) < IDLE_PCT);
        end
    end

    function automatic logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // coordinates inside the image, biased to the edges of large images
    function automatic int pick_coord(int n);
        if (n > 16 && $urandom_range(3) != 0)
            return $urandom_range(1) ? $urandom_range(3) : n - 1 - $urandom_range(3);
        return $urandom_range(n - 1);
    endfunction

    task automatic push_beat(logic [REQ_W-1:0] req, int row, int col,
                             logic signed [VALUE_W-1:0] value);
        t_beat bt;
        bt.req   = req;
        bt.row   = row;
        bt.col   = col;
        bt.value = value;
        request_queue.push_back(bt);
        if (req == REQ_PIXEL) begin
            pix_set[row * CBM_MAX_COLS + col] = 1'b1;
            issued_beats++;
        end else if (req == REQ_COEF) begin
            if (row < CBM_MAX_KERNEL && col < CBM_MAX_KERNEL) begin
                coef_set[row * CBM_MAX_KERNEL + col] = 1'b1;
                issued_beats++;
            end
        end else if (req == REQ_COMPUTE) begin
            issued_beats++;
        end
    endtask

    // compute beat, preceded by writes of any tap it would read unwritten
    task automatic push_compute(int row, int col);
        int nr, nc, y, x;
        nr = eff_dim(rows_reg, CBM_MAX_ROWS);
        nc = eff_dim(cols_reg, CBM_MAX_COLS);
        if (kr_reg[0] && kc_reg[0] && row < nr && col < nc) begin
            for (int a = 0; a < kr_reg; a++) begin
                for (int b = 0; b < kc_reg; b++) begin
                    if (!coef_set[a * CBM_MAX_KERNEL + b])
                        push_beat(REQ_COEF, a, b, rand_value());
                end
            end
            for (int a = 0; a < kr_reg; a++) begin
                y = fold_coord(row + a - kr_reg / 2, nr);
                if (y < 0) continue;
                for (int b = 0; b < kc_reg; b++) begin
                    x = fold_coord(col + b - kc_reg / 2, nc);
                    if (x < 0) continue;
                    if (!pix_set[y * CBM_MAX_COLS + x])
                        push_beat(REQ_PIXEL, y, x, rand_value());
                end
            end
        end
        push_beat(REQ_COMPUTE, row, col, VALUE_W'($urandom));
    endtask

    // mostly computes inside the image, with writes and noise mixed in
    task automatic run_random(int n);
        int target, nr, nc, pick;
        target = issued_beats + n;
        nr = eff_dim(rows_reg, CBM_MAX_ROWS);
        nc = eff_dim(cols_reg, CBM_MAX_COLS);
        while (issued_beats < target) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                if ($urandom_range(3) == 0)
                    push_beat(REQ_COEF, $urandom_range(127), $urandom_range(127),
                              rand_value());
                else
                    push_beat(REQ_COEF, $urandom_range(CBM_MAX_KERNEL - 1),
                              $urandom_range(CBM_MAX_KERNEL - 1), rand_value());
            end else if (pick < 30) begin
                if ($urandom_range(4) == 0)
                    push_beat(REQ_PIXEL, $urandom_range(127), $urandom_range(127),
                              rand_value());
                else
                    push_beat(REQ_PIXEL, pick_coord(nr), pick_coord(nc), rand_value());
            end else if (pick < 33) begin
                push_beat(REQ_UNUSED, $urandom_range(127), $urandom_range(127),
                          rand_value());
            end else if ($urandom_range(6) == 0) begin
                push_compute($urandom_range(127), $urandom_range(127));
            end else begin
                push_compute(pick_coord(nr), pick_coord(nc));
            end
        end
    endtask

    // wait for every beat sent and every sample back, then let the block settle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (request_queue.size() != 0 || i_in_valid || expected_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_IMAGE_ROWS:  rows_reg = data;
            CFG_IMAGE_COLS:  cols_reg = data;
            CFG_KERNEL_ROWS: kr_reg = data[KER_DIM_W-1:0];
            CFG_KERNEL_COLS: kc_reg = data[KER_DIM_W-1:0];
            CFG_BORDER_MODE: border_reg = t_border'(data[1:0]);
            default: ;
        endcase
    endtask

    task automatic set_config(int rows, int cols, int kr, int kc, t_border bm);
        wait_drained();
        write_reg(CFG_IMAGE_ROWS, rows);
        write_reg(CFG_IMAGE_COLS, cols);
        write_reg(CFG_KERNEL_ROWS, kr);
        write_reg(CFG_KERNEL_COLS, kc);
        write_reg(CFG_BORDER_MODE, bm);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset values: 1x1 image, 1x1 kernel, zero border
        push_beat(REQ_COEF, 0, 0, 16'sh7fff);
        push_beat(REQ_PIXEL, 0, 0, 16'sh8000);
        push_compute(0, 0);
        push_beat(REQ_COEF, 0, 0, 16'sh8000);
        push_compute(0, 0);
        // coefficient writes past the kernel store are dropped
        push_beat(REQ_COEF, 7, 0, 16'sh0005);
        push_beat(REQ_COEF, 0, 127, 16'sh0005);
        push_beat(REQ_COEF, 127, 127, 16'sh7fff);
        push_compute(0, 0);
        // pixels outside the image in use are stored but not used
        push_beat(REQ_PIXEL, 127, 127, 16'sh7fff);
        push_beat(REQ_PIXEL, 0, 127, 16'sh1234);
        push_compute(127, 127);
        push_compute(0, 1);
        push_compute(1, 0);
        push_beat(REQ_UNUSED, 127, 127, 16'shffff);
        push_beat(REQ_UNUSED, 0, 0, 16'sh0000);
        push_compute(0, 0);

        // even kernel wins over a position outside the image
        set_config(5, 6, 2, 3, BORDER_ZERO);
        write_reg(CFG_UNUSED, 8'hff);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        push_compute(0, 0);
        push_compute(127, 127);

        // zero and oversized image sizes, zero kernel width
        set_config(0, 255, 3, 0, BORDER_CLAMP);
        push_compute(0, 0);

        set_config(4, 4, 3, 3, BORDER_ZERO);
        run_random(80);
        set_config(1, 1, 7, 7, BORDER_MIRROR);
        run_random(40);
        set_config(0, 255, 5, 1, BORDER_PERIODIC);
        run_random(40);
        set_config(128, 128, 7, 7, BORDER_CLAMP);
        run_random(100);

        // long stretch with no gaps on either side
        steady_flow = 1'b1;
        set_config(7, 3, 1, 7, BORDER_PERIODIC);
        run_random(80);
        wait_drained();
        steady_flow = 1'b0;

        // receiver holds off while beats keep coming, so the input backs up
        set_config(3, 9, 7, 5, BORDER_MIRROR);
        hold_armed = 1'b1;
        run_random(80);

        set_config(8, 8, 3, 5, BORDER_ZERO);
        run_random(80);
        set_config(2, 5, 5, 5, BORDER_CLAMP);
        run_random(80);
        set_config(6, 6, 6, 7, BORDER_MIRROR);
        run_random(20);

        for (int p = 0; p < 3; p++) begin
            set_config($urandom_range(1, 10), $urandom_range(1, 10),
                       2 * $urandom_range(3) + 1, 2 * $urandom_range(3) + 1,
                       t_border'($urandom_range(3)));
            run_random(40);
        end

        wait_drained();
        if (error_count == 0)
            $display("correlation_2d_border_modes_unit_test: clean");
        else
            $display("correlation_2d_border_modes_unit_test: errors");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("correlation_2d_border_modes_unit_test: errors");
        $finish;
    end

endmodule
